@@ rtl/uvmvm_pkg.sv @@
// Shared types, codes and constants of the UV mirror vertex matcher.
`default_nettype none
package uvmvm_pkg;

  // Fixed-point format of coordinates and squared distances
  localparam int FRAC_BITS      = 16;
  localparam int MAX_VERTS_DEF  = 1024;

  localparam int IDX_W   = 16;
  localparam int COORD_W = 20;
  localparam int HU_W    = 22;  // mirrored u needs two more bits
  localparam int SQ_W    = 46;  // register format of squared distances
  localparam int DIST_W  = 44;  // largest sum of squares that can occur

  // Operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_MATCH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_AXIS      = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_BELOW     = 2'd3;

  // Reset values: axis 0.5, tolerance 0.01 squared, threshold 0.000001 squared
  localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FRAC_BITS);
  localparam logic signed [COORD_W-1:0] AXIS_RESET = COORD_W'(1 << (FRAC_BITS - 1));
  localparam logic [SQ_W-1:0] TOL_RESET = SQ_W'((ONE_SQ + 64'd5000) / 64'd10000);
  localparam logic [SQ_W-1:0] THR_RESET =
      SQ_W'((ONE_SQ + 64'd500000000000) / 64'd1000000000000);

  typedef struct packed {
    logic [1:0]                operation;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] u_coord;
    logic signed [COORD_W-1:0] v_coord;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] low_vertex;
    logic [IDX_W-1:0] high_vertex;
    logic             matched;
    logic             exhausted;
    logic             overflowed;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0]          index;
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
  } low_entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]          index;
    logic signed [HU_W-1:0]    u;
    logic signed [COORD_W-1:0] v;
  } high_entry_t;

  // One high entry on its way through the distance unit
  typedef struct packed {
    logic        valid;
    logic        live;
    high_entry_t entry;
  } scan_beat_t;

  // Status of the distance unit back to the sequencer
  typedef struct packed {
    logic             busy;
    logic             found;
    logic             hit;
    logic [IDX_W-1:0] best_index;
  } dist_res_t;

endpackage
`default_nettype wire

@@ rtl/uvmvm_tables.sv @@
// Low-side and high-side vertex tables with their live bits.
`default_nettype none
module uvmvm_tables #(
  parameter int MAX_VERTS = uvmvm_pkg::MAX_VERTS_DEF,
  localparam int AW = $clog2(MAX_VERTS)
) (
  input  wire logic                     clk,
  input  wire logic                     low_we,
  input  wire logic [AW-1:0]            low_waddr,
  input  wire uvmvm_pkg::low_entry_t    low_wdata,
  input  wire logic [AW-1:0]            low_raddr,
  output uvmvm_pkg::low_entry_t         low_rdata,
  input  wire logic                     high_we,
  input  wire logic [AW-1:0]            high_waddr,
  input  wire uvmvm_pkg::high_entry_t   high_wdata,
  input  wire logic                     live_we,
  input  wire logic [AW-1:0]            live_waddr,
  input  wire logic                     live_wdata,
  input  wire logic [AW-1:0]            high_raddr,
  output uvmvm_pkg::high_entry_t        high_rdata,
  output logic                          live_rdata
);

  uvmvm_pkg::low_entry_t  low_mem  [MAX_VERTS];
  uvmvm_pkg::high_entry_t high_mem [MAX_VERTS];
  logic                   live_mem [MAX_VERTS];

  // Low table: written by loads, read at the next entry to match
  always_ff @(posedge clk) begin
    if (low_we) begin
      low_mem[low_waddr] <= low_wdata;
    end
    low_rdata <= low_mem[low_raddr];
  end

  // High table: written by loads, read by the scan
  always_ff @(posedge clk) begin
    if (high_we) begin
      high_mem[high_waddr] <= high_wdata;
    end
    high_rdata <= high_mem[high_raddr];
  end

  // Live bits: set by loads, dropped when an entry is retired
  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[live_waddr] <= live_wdata;
    end
    live_rdata <= live_mem[high_raddr];
  end

endmodule
`default_nettype wire

@@ rtl/uvmvm_dist.sv @@
// Pipelined squared-distance unit with best-candidate tracking.
`default_nettype none
module uvmvm_dist #(
  parameter int AW = 10
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [uvmvm_pkg::COORD_W-1:0]  lo_u,
  input  wire logic signed [uvmvm_pkg::COORD_W-1:0]  lo_v,
  input  wire logic [uvmvm_pkg::SQ_W-1:0]            tolerance,
  input  wire logic [uvmvm_pkg::SQ_W-1:0]            threshold,
  input  wire uvmvm_pkg::scan_beat_t                 beat,
  input  wire logic [AW-1:0]                         beat_addr,
  output uvmvm_pkg::dist_res_t                       res,
  output logic [AW-1:0]                              best_addr
);

  localparam int DU_W = uvmvm_pkg::HU_W + 1;
  localparam int DV_W = uvmvm_pkg::COORD_W + 1;

  // Stage 1: differences
  logic                         v1, live1;
  logic [uvmvm_pkg::IDX_W-1:0]  idx1;
  logic [AW-1:0]                addr1;
  logic signed [DU_W-1:0]       du;
  logic signed [DV_W-1:0]       dv;
  // Stage 2: squares
  logic                         v2, live2;
  logic [uvmvm_pkg::IDX_W-1:0]  idx2;
  logic [AW-1:0]                addr2;
  logic [uvmvm_pkg::DIST_W-1:0] sq_u, sq_v;
  // Stage 3: sum
  logic                         v3, live3;
  logic [uvmvm_pkg::IDX_W-1:0]  idx3;
  logic [AW-1:0]                addr3;
  logic [uvmvm_pkg::DIST_W-1:0] dsq;
  // Tracker
  logic                         found, hit;
  logic [uvmvm_pkg::DIST_W-1:0] best_d;
  logic [uvmvm_pkg::IDX_W-1:0]  best_index;

  logic signed [2*DU_W-1:0]     prod_u;
  logic signed [2*DV_W-1:0]     prod_v;
  logic [uvmvm_pkg::SQ_W-1:0]   dist_ext;
  logic                         cand, in_tol, at_thr, closer;

  assign prod_u   = du * du;
  assign prod_v   = dv * dv;
  assign dist_ext = uvmvm_pkg::SQ_W'(dsq);
  assign in_tol   = dist_ext <= tolerance;
  assign at_thr   = dist_ext <= threshold;
  assign closer   = !found || (dsq <= best_d);
  assign cand     = v3 && live3 && !hit && in_tol;

  // Advance the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= beat.valid;
      v2 <= v1;
      v3 <= v2;
    end
    live1 <= beat.live;
    idx1  <= beat.entry.index;
    addr1 <= beat_addr;
    du    <= DU_W'(lo_u) - DU_W'(beat.entry.u);
    dv    <= DV_W'(lo_v) - DV_W'(beat.entry.v);
    live2 <= live1;
    idx2  <= idx1;
    addr2 <= addr1;
    sq_u  <= prod_u[uvmvm_pkg::DIST_W-1:0];
    sq_v  <= uvmvm_pkg::DIST_W'(prod_v);
    live3 <= live2;
    idx3  <= idx2;
    addr3 <= addr2;
    dsq   <= sq_u + sq_v;
  end

  // Keep the winner: first at threshold stops, else nearest with later on ties
  always_ff @(posedge clk) begin
    if (rst || start) begin
      found <= 1'b0;
      hit   <= 1'b0;
    end else if (cand && (at_thr || closer)) begin
      found <= 1'b1;
      hit   <= at_thr;
    end
    if (cand && (at_thr || closer)) begin
      best_d     <= dsq;
      best_index <= idx3;
      best_addr  <= addr3;
    end
  end

  assign res.busy       = v1 || v2 || v3;
  assign res.found      = found;
  assign res.hit        = hit;
  assign res.best_index = best_index;

endmodule
`default_nettype wire

@@ rtl/uv_mirror_vertex_matcher_unit.sv @@
// Top level of the UV mirror vertex matcher: sequencer, registers, output stage.
`default_nettype none
// Loads sort a vertex to the low table or, with u mirrored about the axis, to the
// high table; clear empties both. Load, clear and the unused code are handled
// without leaving the idle state. A match reads the next low vertex and streams the
// high entries loaded since the last clear, one a cycle, through a single shared
// distance pipeline, then waits for the pipeline to drain; the scan ends early once
// a live entry within the tolerance and at or below the threshold is seen. A match
// with no low vertex left skips the scan and reports the low side exhausted. The
// result sits in an output register, so the next item is taken while it waits.
// Tables need no clearing pass: only entries below the fill counts are ever read.
module uv_mirror_vertex_matcher_unit #(
  parameter int MAX_VERTS = uvmvm_pkg::MAX_VERTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire uvmvm_pkg::in_t                  in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output uvmvm_pkg::out_t                      out_data,
  input  wire logic                            cfg_write,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [uvmvm_pkg::SQ_W-1:0]      cfg_data
);

  localparam int AW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_VERTS);

  typedef enum logic [2:0] {S_IDLE, S_LFETCH, S_SCAN, S_DRAIN, S_RESULT} state_t;

  state_t state;

  // Configuration registers
  logic signed [uvmvm_pkg::COORD_W-1:0] mirror_axis;
  logic [uvmvm_pkg::SQ_W-1:0]           tolerance;
  logic [uvmvm_pkg::SQ_W-1:0]           threshold;
  logic                                 below;

  // Table state
  logic [CW-1:0] low_count, high_count, low_next, scan_i;
  logic          overflow_flag;
  logic          rd_valid;
  logic [AW-1:0] rd_addr;
  uvmvm_pkg::low_entry_t lo_q;
  uvmvm_pkg::out_t       res_q;

  // Table ports
  uvmvm_pkg::low_entry_t  low_wdata, low_rdata;
  uvmvm_pkg::high_entry_t high_wdata, high_rdata;
  logic                   high_live;
  logic                   low_we, high_we, live_we, live_wdata;
  logic [AW-1:0]          live_waddr;

  // Distance unit ports
  uvmvm_pkg::scan_beat_t beat;
  uvmvm_pkg::dist_res_t  dres;
  logic [AW-1:0]         best_addr;

  logic                  accept, is_load, is_low, issue, drain_done;
  logic signed [uvmvm_pkg::HU_W-1:0] mirrored_u;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_load  = accept && (in_data.operation == uvmvm_pkg::OP_LOAD);
  assign is_low   = below ? (in_data.u_coord < mirror_axis) : (in_data.u_coord > mirror_axis);
  assign mirrored_u = (uvmvm_pkg::HU_W'(mirror_axis) <<< 1) - uvmvm_pkg::HU_W'(in_data.u_coord);

  assign low_wdata.index  = in_data.vertex_index;
  assign low_wdata.u      = in_data.u_coord;
  assign low_wdata.v      = in_data.v_coord;
  assign high_wdata.index = in_data.vertex_index;
  assign high_wdata.u     = mirrored_u;
  assign high_wdata.v     = in_data.v_coord;

  assign low_we  = is_load && is_low && (low_count != FULL);
  assign high_we = is_load && !is_low && (high_count != FULL);

  assign issue      = (state == S_SCAN) && (scan_i != high_count) && !dres.hit;
  assign drain_done = (state == S_DRAIN) && !rd_valid && !dres.busy;

  // Live bit: set on a high load, dropped when the winner retires
  assign live_we    = high_we || (drain_done && dres.found);
  assign live_waddr = drain_done ? best_addr : high_count[AW-1:0];
  assign live_wdata = !drain_done;

  assign beat.valid = rd_valid;
  assign beat.live  = high_live;
  assign beat.entry = high_rdata;

  uvmvm_tables #(.MAX_VERTS(MAX_VERTS)) u_tables (
    .clk        (clk),
    .low_we     (low_we),
    .low_waddr  (low_count[AW-1:0]),
    .low_wdata  (low_wdata),
    .low_raddr  (low_next[AW-1:0]),
    .low_rdata  (low_rdata),
    .high_we    (high_we),
    .high_waddr (high_count[AW-1:0]),
    .high_wdata (high_wdata),
    .live_we    (live_we),
    .live_waddr (live_waddr),
    .live_wdata (live_wdata),
    .high_raddr (scan_i[AW-1:0]),
    .high_rdata (high_rdata),
    .live_rdata (high_live)
  );

  uvmvm_dist #(.AW(AW)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .start     (state == S_LFETCH),
    .lo_u      (lo_q.u),
    .lo_v      (lo_q.v),
    .tolerance (tolerance),
    .threshold (threshold),
    .beat      (beat),
    .beat_addr (rd_addr),
    .res       (dres),
    .best_addr (best_addr)
  );

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_axis <= uvmvm_pkg::AXIS_RESET;
      tolerance   <= uvmvm_pkg::TOL_RESET;
      threshold   <= uvmvm_pkg::THR_RESET;
      below       <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        uvmvm_pkg::REG_AXIS:      mirror_axis <= cfg_data[uvmvm_pkg::COORD_W-1:0];
        uvmvm_pkg::REG_TOLERANCE: tolerance   <= cfg_data;
        uvmvm_pkg::REG_THRESHOLD: threshold   <= cfg_data;
        uvmvm_pkg::REG_BELOW:     below       <= cfg_data[0];
        default:                  ;
      endcase
    end
  end

  // Sequencer, table counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      low_count     <= '0;
      high_count    <= '0;
      low_next      <= '0;
      scan_i        <= '0;
      overflow_flag <= 1'b0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rd_valid <= issue;
      // Drop the result beat once taken, unless a new one replaces it below
      if (out_valid && out_ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.operation)
              uvmvm_pkg::OP_LOAD: begin
                if (is_low) begin
                  if (low_count == FULL) overflow_flag <= 1'b1;
                  else low_count <= low_count + 1'b1;
                end else begin
                  if (high_count == FULL) overflow_flag <= 1'b1;
                  else high_count <= high_count + 1'b1;
                end
              end
              uvmvm_pkg::OP_MATCH: begin
                if (low_next >= low_count) begin
                  res_q.low_vertex  <= '0;
                  res_q.high_vertex <= '0;
                  res_q.matched     <= 1'b0;
                  res_q.exhausted   <= 1'b1;
                  res_q.overflowed  <= overflow_flag;
                  state             <= S_RESULT;
                end else begin
                  low_next <= low_next + 1'b1;
                  state    <= S_LFETCH;
                end
              end
              uvmvm_pkg::OP_CLEAR: begin
                low_count     <= '0;
                high_count    <= '0;
                low_next      <= '0;
                overflow_flag <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_LFETCH: begin
          lo_q   <= low_rdata;
          scan_i <= '0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (issue) begin
            rd_addr <= scan_i[AW-1:0];
            scan_i  <= scan_i + 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_done) begin
            res_q.low_vertex  <= lo_q.index;
            res_q.high_vertex <= dres.found ? dres.best_index : '0;
            res_q.matched     <= dres.found;
            res_q.exhausted   <= 1'b0;
            res_q.overflowed  <= overflow_flag;
            state             <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_data  <= res_q;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ verif/uvmvm_pair_monitor.sv @@
// Pairing monitor for the UV mirror vertex matcher: predicts each pair and compares it.
`timescale 1ns / 100ps
module uvmvm_pair_monitor
  import uvmvm_pkg::*;
#(
  parameter int NVERTS = MAX_VERTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_t                 in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_t                out_data,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [SQ_W-1:0]     cfg_data,
  output int                  mismatches,
  output int                  pending
);

  // High side: mirrored vertices in load order, retired ones keep their slot
  logic [IDX_W-1:0]          hi_index [NVERTS];
  logic signed [HU_W-1:0]    hi_u     [NVERTS];
  logic signed [COORD_W-1:0] hi_v     [NVERTS];
  bit                        hi_live  [NVERTS];
  int unsigned               hi_fill;

  // Low side: source vertices waiting for a match request
  logic [IDX_W-1:0]          lo_index [NVERTS];
  logic signed [COORD_W-1:0] lo_u     [NVERTS];
  logic signed [COORD_W-1:0] lo_v     [NVERTS];
  int unsigned               lo_fill;
  int unsigned               lo_head;
  bit                        dropped;

  // Register copies
  logic signed [COORD_W-1:0] axis_u;
  logic [SQ_W-1:0]           tol_sq;
  logic [SQ_W-1:0]           thr_sq;
  bit                        low_below;

  out_t                      pairs_due [$];
  out_t                      due;
  int                        bad;

  function automatic string show(input out_t r);
    return $sformatf("low %0d high %0d matched %0b exhausted %0b overflowed %0b",
                     r.low_vertex, r.high_vertex, r.matched, r.exhausted, r.overflowed);
  endfunction

  task automatic empty_tables();
    foreach (hi_live[i]) hi_live[i] = 1'b0;
    hi_fill = 0;
    lo_fill = 0;
    lo_head = 0;
    dropped = 1'b0;
  endtask

  // Sort one vertex to its side; drop it when that table is full
  task automatic sort_vertex(input in_t b);
    bit to_low;
    to_low = low_below ? (b.u_coord < axis_u) : (b.u_coord > axis_u);
    if (to_low) begin
      if (lo_fill >= NVERTS) begin
        dropped = 1'b1;
      end else begin
        lo_index[lo_fill] = b.vertex_index;
        lo_u[lo_fill]     = b.u_coord;
        lo_v[lo_fill]     = b.v_coord;
        lo_fill++;
      end
    end else begin
      if (hi_fill >= NVERTS) begin
        dropped = 1'b1;
      end else begin
        hi_index[hi_fill] = b.vertex_index;
        hi_u[hi_fill]     = HU_W'(2 * int'(axis_u) - int'(b.u_coord));
        hi_v[hi_fill]     = b.v_coord;
        hi_live[hi_fill]  = 1'b1;
        hi_fill++;
      end
    end
  endtask

  // Pair the next low vertex with the best live high entry
  task automatic pair_next_low();
    out_t        r;
    longint      du, dv, dsq, best_d;
    int unsigned k, i, best;
    bit          found;
    r = '0;
    if (lo_head >= lo_fill) begin
      r.exhausted = 1'b1;
    end else begin
      k = lo_head;
      lo_head++;
      found  = 1'b0;
      best   = 0;
      best_d = 64'h7fff_ffff_ffff_ffff;
      for (i = 0; i < hi_fill; i++) begin
        if (!hi_live[i]) continue;
        du  = longint'(lo_u[k]) - longint'(hi_u[i]);
        dv  = longint'(lo_v[k]) - longint'(hi_v[i]);
        dsq = du * du + dv * dv;
        if (dsq > longint'(tol_sq)) continue;
        // close enough: take it at once
        if (dsq <= longint'(thr_sq)) begin
          found = 1'b1;
          best  = i;
          break;
        end
        // nearest so far, later entry wins a tie
        if (dsq <= best_d) begin
          best_d = dsq;
          best   = i;
          found  = 1'b1;
        end
      end
      r.low_vertex = lo_index[k];
      if (found) begin
        hi_live[best] = 1'b0;
        r.high_vertex = hi_index[best];
        r.matched     = 1'b1;
      end
    end
    r.overflowed = dropped;
    pairs_due.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      empty_tables();
      axis_u    = AXIS_RESET;
      tol_sq    = TOL_RESET;
      thr_sq    = THR_RESET;
      low_below = 1'b1;
      pairs_due.delete();
      bad = 0;
    end else begin
      // Track register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_AXIS:      axis_u    = cfg_data[COORD_W-1:0];
          REG_TOLERANCE: tol_sq    = cfg_data;
          REG_THRESHOLD: thr_sq    = cfg_data;
          REG_BELOW:     low_below = cfg_data[0];
        endcase
      end
      // Advance the prediction on each accepted request beat
      if (in_valid && in_ready) begin
        case (in_data.operation)
          OP_LOAD:  sort_vertex(in_data);
          OP_MATCH: pair_next_low();
          OP_CLEAR: empty_tables();
          default:  ;  // unused code, dropped by the block
        endcase
      end
      // Compare each result beat with the oldest pending pair
      if (out_valid && out_ready) begin
        if (pairs_due.size() == 0) begin
          bad++;
          $display("%0t: unexpected result beat: %s", $time, show(out_data));
        end else begin
          due = pairs_due.pop_front();
          if (out_data !== due) begin
            bad++;
            $display("%0t: pair mismatch: expected %s", $time, show(due));
            $display("%0t:                got      %s", $time, show(out_data));
          end
        end
      end
    end
    mismatches <= bad;
    pending    <= pairs_due.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the UV mirror vertex matcher: stimulus, register setup and verdict.
`timescale 1ns / 100ps
module tb;
  import uvmvm_pkg::*;

  localparam int NVERTS      = MAX_VERTS_DEF;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int ITEM_BEATS  = 580;
  localparam int SETTLE      = NVERTS + 64;
  localparam int C_MIN       = -(1 << (COORD_W - 1));
  localparam int C_MAX       = (1 << (COORD_W - 1)) - 1;
  localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};
  localparam logic [1:0] OP_NONE = 2'd3;  // unused code, ignored by the block

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  in_t             in_data;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_t            out_data;
  logic            cfg_write;
  logic [1:0]      cfg_index;
  logic [SQ_W-1:0] cfg_data;
  int              mismatches;
  int              pending;

  bit calm;        // no gaps on either side while set
  int stall_left;
  int cycles;
  int beats_sent;
  int match_reqs;
  int settings;
  int cur_axis;
  bit cur_below;

  uv_mirror_vertex_matcher_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  uvmvm_pair_monitor i_pair_mon (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 30) begin
      stall_left = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb failed");
      $finish;
    end
  end

  function automatic int clamp_u(input int x);
    return (x < C_MIN) ? C_MIN : ((x > C_MAX) ? C_MAX : x);
  endfunction

  function automatic int rand_coord();
    return C_MIN + int'($urandom_range(0, (1 << COORD_W) - 1));
  endfunction

  function automatic in_t vertex(input int idx, input int u, input int v);
    in_t b;
    b.operation    = OP_LOAD;
    b.vertex_index = IDX_W'(idx);
    b.u_coord      = COORD_W'(u);
    b.v_coord      = COORD_W'(v);
    return b;
  endfunction

  // Non-load request; the unused fields carry junk
  function automatic in_t command(input logic [1:0] op);
    in_t b;
    b.operation    = op;
    b.vertex_index = IDX_W'($urandom);
    b.u_coord      = COORD_W'($urandom);
    b.v_coord      = COORD_W'($urandom);
    return b;
  endfunction

  // Present one request beat and hold it until accepted; returns on the accepting edge
  task automatic push_beat(input in_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (b.operation == OP_MATCH) match_reqs++;
  endtask

  // Stop sending and wait for every pending pair, then for the short ops to finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic program_regs(input int axis, input logic [SQ_W-1:0] tol,
                              input logic [SQ_W-1:0] thr, input bit below);
    cfg_write <= 1'b1;
    cfg_index <= REG_AXIS;
    cfg_data  <= SQ_W'(axis);
    @(posedge clk);
    cfg_index <= REG_TOLERANCE;
    cfg_data  <= tol;
    @(posedge clk);
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= REG_BELOW;
    cfg_data  <= SQ_W'(below);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    cur_axis  = axis;
    cur_below = below;
    settings++;
  endtask

  // Corner cases under reset settings, then at both axis extremes
  task automatic run_directed();
    push_beat(command(OP_MATCH));                 // nothing loaded yet
    push_beat(vertex(16'hFFFF, C_MIN, C_MAX));    // low, far from everything
    push_beat(vertex(0, C_MAX, C_MIN));           // high, far
    push_beat(vertex(100, 20000, 1000));          // low
    push_beat(vertex(200, 45536, 1010));          // high, mirror at distance 10
    push_beat(vertex(201, 45536, 990));           // same distance, later entry
    push_beat(vertex(300, 32768, 0));             // exactly on the axis goes high
    push_beat(command(OP_MATCH));                 // no partner
    push_beat(command(OP_MATCH));                 // tie: later entry wins
    push_beat(command(OP_NONE));
    push_beat(command(OP_MATCH));                 // low side exhausted
    push_beat(vertex(400, 20000, 1000));
    push_beat(command(OP_MATCH));                 // remaining tie partner
    push_beat(command(OP_CLEAR));
    push_beat(command(OP_MATCH));
    drain();
    // threshold above tolerance: first entry within tolerance wins
    program_regs(C_MIN, 1000, SQ_MAX, 1'b0);
    push_beat(vertex(7, C_MIN + 1, 0));
    push_beat(vertex(8, C_MIN, 20));
    push_beat(vertex(9, C_MIN, 0));
    push_beat(vertex(10, C_MIN, 40));
    push_beat(command(OP_MATCH));
    drain();
    // zero tolerance at the top of the axis range
    program_regs(C_MAX, '0, '0, 1'b1);
    push_beat(vertex(11, C_MAX, C_MAX));
    push_beat(vertex(12, C_MAX - 1, C_MAX));
    push_beat(command(OP_MATCH));
    push_beat(command(OP_MATCH));
  endtask

  task automatic pick_settings();
    logic [SQ_W-1:0] tol, thr;
    int              r, axis;
    r = $urandom_range(0, 9);
    axis = (r == 0) ? C_MIN : (r == 1) ? C_MAX : int'($urandom_range(0, 400000)) - 200000;
    case ($urandom_range(0, 4))
      0:       tol = '0;
      1:       tol = SQ_W'($urandom_range(0, 4000));
      2:       tol = TOL_RESET;
      3:       tol = SQ_W'({$urandom, $urandom});
      default: tol = SQ_MAX;
    endcase
    case ($urandom_range(0, 4))
      0:       thr = '0;
      1:       thr = tol >> 2;
      2:       thr = tol;
      3:       thr = tol + SQ_W'($urandom_range(1, 100000));
      default: thr = SQ_MAX;
    endcase
    program_regs(axis, tol, thr, $urandom_range(0, 1));
  endtask

  // One burst of mirrored pairs with jitter, ties, junk loads and match requests
  task automatic run_sequence();
    in_t plan [$];
    int  lows, s, d, e_u, lu, hu, lv, hv, spread, p, idx;
    if ($urandom_range(0, 2) == 0) begin
      drain();
      pick_settings();
    end
    calm = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 4))
      0:       spread = 0;
      1:       spread = 4;
      2:       spread = 300;
      3:       spread = 700;
      default: spread = 3000;
    endcase
    s = cur_below ? -1 : 1;
    lows = $urandom_range(1, 16);
    for (p = 0; p < lows; p++) begin
      d   = $urandom_range(1, 200000);
      e_u = int'($urandom_range(0, 2 * spread)) - spread;
      lu  = clamp_u(cur_axis + s * d);
      hu  = clamp_u(cur_axis - s * d - s * e_u);
      lv  = rand_coord();
      hv  = clamp_u(lv + int'($urandom_range(0, 2 * spread)) - spread);
      plan.insert($urandom_range(0, plan.size()), vertex($urandom_range(0, 65535), lu, lv));
      idx = $urandom_range(0, 65535);
      plan.insert($urandom_range(0, plan.size()), vertex(idx, hu, hv));
      // duplicate partner: equal distance, the later copy wins unless the first is at or below the threshold
      if ($urandom_range(0, 6) == 0)
        plan.insert($urandom_range(0, plan.size()), vertex(idx ^ 1, hu, hv));
    end
    repeat ($urandom_range(0, 2))
      plan.insert($urandom_range(0, plan.size()),
                  vertex($urandom_range(0, 65535), rand_coord(), rand_coord()));
    if ($urandom_range(0, 4) == 0)
      plan.insert($urandom_range(0, plan.size()), command(OP_NONE));
    if ($urandom_range(0, 2) == 0)
      plan.insert($urandom_range(0, plan.size()), command(OP_MATCH));
    repeat (lows + $urandom_range(0, 2)) plan.push_back(command(OP_MATCH));
    if ($urandom_range(0, 9) < 7) plan.push_front(command(OP_CLEAR));
    foreach (plan[i]) begin
      push_beat(plan[i]);
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = REG_AXIS;
    cfg_data  = '0;
    calm      = 1'b0;
    cur_axis  = AXIS_RESET;
    cur_below = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    while (beats_sent < ITEM_BEATS) run_sequence();

    calm = 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);

    $display("Summary: %0d request beats (%0d match requests) under %0d register settings,",
             beats_sent, match_reqs, settings);
    $display("covering corner pairs, ties, axis extremes and random mirrored pair bursts.");
    if (mismatches == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/uvmvm_pkg.sv
rtl/uvmvm_tables.sv
rtl/uvmvm_dist.sv
rtl/uv_mirror_vertex_matcher_unit.sv
verif/uvmvm_pair_monitor.sv
verif/tb.sv
